// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, sizes, character codes and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ROWS     = 25;
  localparam int COLS     = 80;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = ROWS * COLS;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  // number of tab stops a column can reach, the last one may lie past the row
  localparam int TAB_STOPS = (COLS - 1) / TAB_STOP + 1;

  localparam logic [CELL_W-1:0] SCROLL_FILL_RST = 16'h0720;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SET   = 2'd2,
    MODE_READ  = 2'd3
  } tcw_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_HOLD
  } tcw_state_e;

  typedef struct packed {
    tcw_mode_e           mode;
    logic [CHAR_W-1:0]   char_code;
    logic [CELL_W-1:0]   fill_value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } tcw_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic [POS_W-1:0]    hw_cursor_pos;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
  } tcw_out_t;

  function automatic logic [ROW_W-1:0] clamp_row(logic [ROW_W-1:0] r);
    return (r > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(logic [COL_W-1:0] c);
    return (c > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : c;
  endfunction

  // linear cell index row*COLS+col, only called with an on-screen position
  function automatic logic [ADDR_W-1:0] lin_pos(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c));
  endfunction

  // next tab stop strictly right of the column: compare against every stop
  function automatic logic [COL_W:0] tab_next(logic [COL_W-1:0] c);
    logic [COL_W:0] res;
    res = '0;
    for (int k = TAB_STOPS; k >= 1; k--) begin
      if ({1'b0, c} < (COL_W+1)'(k * TAB_STOP)) begin
        res = (COL_W+1)'(k * TAB_STOP);
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: a ROWS x COLS cell store in one RAM and a cursor.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Word
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o | tcw_in_t  (mode, char, ...)
//  out     | output    | out_valid_o/out_ready_i | tcw_out_t (cursor, cell, ...)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | scroll_fill, 16 bits
//
//  Steps: set cursor, NUL and control codes that move without scrolling
//  finish from the idle state; printable characters and cell reads do a RAM
//  read, then write back or capture. Clear writes every cell with the fill
//  value, one cell write a cycle. A scroll adds a pipelined row-up copy
//  through the RAM's read and write ports followed by the bottom-row fill.
//  Reset clears the cursor and control state only; the cell store stays
//  undefined until a clear, and there is no clearing pass.
//  Stalls: the output register holds a word while the next item is taken;
//  an item that finishes while that word waits is held until it drains.
//
module text_console_writer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import tcw_pkg::*;

  tcw_state_e        state_q, state_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [POS_W-1:0]  hw_q, hw_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic              scr_q, scr_d;
  logic [CHAR_W-1:0] code_q, code_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q, out_d;
  logic [CELL_W-1:0] scroll_fill_q;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [ADDR_W-1:0] cur_pos, tgt_pos;
  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  tgt_col;
  logic [COL_W:0]    tab_col;
  logic [CNT_W-1:0]  cnt_m1, cnt_rd;
  logic              out_free;
  logic              finish, nl, go_scroll;

  assign cur_pos  = lin_pos(cur_row_q, cur_col_q);
  assign tgt_row  = clamp_row(in_data_i.row);
  assign tgt_col  = clamp_col(in_data_i.col);
  assign tgt_pos  = lin_pos(tgt_row, tgt_col);
  assign tab_col  = tab_next(cur_col_q);
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign cnt_rd   = cnt_q + CNT_W'(COLS);
  assign out_free = !out_valid_q || out_ready_i;

  // One item in flight at a time: the state machine is the interlock that
  // keeps a read-modify-write apart from the next item's read.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    hw_d        = hw_q;
    cell_d      = cell_q;
    scr_d       = scr_q;
    code_d      = code_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_pos;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = cur_pos;
    finish      = 1'b0;
    nl          = 1'b0;
    go_scroll   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cell_d = '0;
          scr_d  = 1'b0;
          case (in_data_i.mode)
            MODE_CHAR: begin
              if (in_data_i.char_code == CH_NUL) begin
                finish = 1'b1;
              end else begin
                // latch the position before the character moves the cursor
                hw_d = POS_W'(cur_pos);
                case (in_data_i.char_code)
                  CH_NL: begin
                    nl = 1'b1;
                  end
                  CH_CR: begin
                    cur_col_d = '0;
                    finish    = 1'b1;
                  end
                  CH_TAB: begin
                    if (tab_col >= (COL_W+1)'(COLS)) begin
                      nl = 1'b1;
                    end else begin
                      cur_col_d = tab_col[COL_W-1:0];
                      finish    = 1'b1;
                    end
                  end
                  CH_BS: begin
                    if (cur_col_q != '0) begin
                      cur_col_d = cur_col_q - COL_W'(1);
                    end
                    finish = 1'b1;
                  end
                  CH_VT: begin
                    finish = 1'b1;
                  end
                  default: begin
                    // fetch the cell to keep its attribute byte
                    ram_re    = 1'b1;
                    ram_raddr = cur_pos;
                    code_d    = in_data_i.char_code;
                    state_d   = ST_CHAR;
                  end
                endcase
              end
            end
            MODE_CLEAR: begin
              fill_d    = in_data_i.fill_value;
              cur_row_d = '0;
              cur_col_d = '0;
              hw_d      = '0;
              cnt_d     = '0;
              state_d   = ST_CLEAR;
            end
            MODE_SET: begin
              cur_row_d = tgt_row;
              cur_col_d = tgt_col;
              hw_d      = POS_W'(tgt_pos);
              finish    = 1'b1;
            end
            MODE_READ: begin
              ram_re    = 1'b1;
              ram_raddr = tgt_pos;
              state_d   = ST_READ;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      ST_CHAR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_pos;
        ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], code_q};
        if (cur_col_q >= COL_W'(COLS - 1)) begin
          nl = 1'b1;
        end else begin
          cur_col_d = cur_col_q + COL_W'(1);
          finish    = 1'b1;
        end
      end

      ST_READ: begin
        cell_d = ram_rdata;
        finish = 1'b1;
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[ADDR_W-1:0];
        ram_wdata = fill_q;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          finish = 1'b1;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_SCROLL: begin
        // read one row below, write the word fetched last cycle one slot back, or the fill in the bottom row
        if (cnt_q < CNT_W'(CELLS - COLS)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_rd[ADDR_W-1:0];
        end
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m1[ADDR_W-1:0];
          ram_wdata = (cnt_q <= CNT_W'(CELLS - COLS)) ? ram_rdata : scroll_fill_q;
        end
        if (cnt_q == CNT_W'(CELLS)) begin
          finish = 1'b1;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_HOLD: begin
        finish = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // go to column 0 of the next row, scroll below the last row
    if (nl) begin
      cur_col_d = '0;
      if (cur_row_q >= ROW_W'(ROWS - 1)) begin
        cur_row_d = ROW_W'(ROWS - 1);
        scr_d     = 1'b1;
        go_scroll = 1'b1;
      end else begin
        cur_row_d = cur_row_q + ROW_W'(1);
        finish    = 1'b1;
      end
    end

    if (go_scroll) begin
      cnt_d   = '0;
      state_d = ST_SCROLL;
    end

    // hand the finished word to the output register, or hold it
    if (finish) begin
      if (out_free) begin
        out_valid_d             = 1'b1;
        out_d.cursor_row        = cur_row_d;
        out_d.cursor_col        = cur_col_d;
        out_d.hw_cursor_pos     = hw_d;
        out_d.cell_value        = cell_d;
        out_d.scrolled          = scr_d;
        state_d                 = ST_IDLE;
      end else begin
        state_d = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cur_row_q     <= '0;
      cur_col_q     <= '0;
      hw_q          <= '0;
      out_valid_q   <= 1'b0;
      scroll_fill_q <= SCROLL_FILL_RST;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        scroll_fill_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    scr_q  <= scr_d;
    code_q <= code_d;
    fill_q <= fill_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tcw_pkg::tcw_out_t out_data_o
);
  import tcw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled output word changed");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cursor_row <= ROW_W'(ROWS - 1)) &&
                    (out_data_o.cursor_col <= COL_W'(COLS - 1)) &&
                    (out_data_o.hw_cursor_pos < POS_W'(CELLS)))
    else $error("cursor off screen");

  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scrolled |->
      (out_data_o.cursor_row == ROW_W'(ROWS - 1)) && (out_data_o.cursor_col == '0))
    else $error("scroll left the cursor away from the bottom row start");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
